[hw/rtl/esg_pkg.sv]
// ----------------------------------------------------------------------------
// esg_pkg - shared types and constants for the ellipse span generator
// Word layouts, datapath widths and configuration register indexes.
// ----------------------------------------------------------------------------
package esg_pkg;

  // signed width of the midpoint decision/step datapath (covers radius 31)
  localparam int unsigned DW = 27;
  // walk column counter and signed row counter
  localparam int unsigned XW = 8;
  localparam int unsigned YW = 8;
  // half-width entry of the row table
  localparam int unsigned EW = 7;

  localparam int unsigned IN_W  = 64;
  localparam int unsigned OUT_W = 56;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 8'd1;

  // output word, rect_x in the lowest bits
  typedef struct packed {
    logic [15:0] color;
    logic [9:0]  height;
    logic [9:0]  width;
    logic [9:0]  y;
    logic [9:0]  x;
  } rect_t;

endpackage

[hw/rtl/ellipse_span_generator.sv]
// ----------------------------------------------------------------------------
// ellipse_span_generator - filled ellipse to clipped fill rectangles
// Turns one filled-ellipse request into screen-clipped rectangles, top down.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request word: center, radii (saturated to MAX_RADIUS)
//   and color. The block takes a word only when idle and drops tready while
//   it works. m_axis returns the rectangles, tlast on the final one; a request
//   that paints nothing returns no word. cfg_* writes screen_width (index 0)
//   and screen_height (index 1), always ready; write only while idle.
// Operation:
//   A line or pixel request yields a single clipped candidate. An ellipse
//   first runs the walk: the shared multiplier setup, then one midpoint
//   step per cycle. It then visits 2*ry+1 rows, each with an address step
//   and a use step set by the registered read of the row table; a stalled
//   receiver can hold a row. A final step places the last word.
//   Each rectangle is held one step so tlast can be placed; the output
//   register lets the next request start while the final word waits.
// Reset clears control state and sets both screen sizes to 240. A stalled
// receiver holds the current word and pauses the sequencer once a further
// rectangle is ready behind the held one.
// ----------------------------------------------------------------------------
module ellipse_span_generator #(
  parameter int unsigned MAX_RADIUS = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // {fill_color, radius_y, radius_x, center_y, center_x}, center_x lowest
  input  logic [esg_pkg::IN_W-1:0]      s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // {rect_color, rect_height, rect_width, rect_y, rect_x}, rect_x lowest
  output logic [esg_pkg::OUT_W-1:0]     m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [esg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [esg_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import esg_pkg::*;

  localparam int unsigned RW = $clog2(MAX_RADIUS + 1);
  localparam int unsigned CW = $clog2(2 * MAX_RADIUS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SPEC   = 3'd1;
  localparam logic [2:0] S_WSTART = 3'd2;
  localparam logic [2:0] S_WWAIT  = 3'd3;
  localparam logic [2:0] S_RADDR  = 3'd4;
  localparam logic [2:0] S_RUSE   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [15:0]   cx_q, cy_q, color_q;
  logic [RW-1:0] rx_q, ry_q;
  logic [CW-1:0] r_q;
  logic [9:0]    sw_q, sh_q;
  logic          hold_v_q, out_v_q, out_last_q;
  rect_t         hold_q, out_q;

  logic          accept;
  logic [RW-1:0] rx_sat, ry_sat;
  logic          walk_done;
  logic [RW-1:0] y_idx;
  logic [EW-1:0] half;
  logic [CW-1:0] r_end;

  logic [17:0] x0s, span_w, py;
  logic [15:0] x0, x_line, y_line;
  logic [15:0] cand_x;
  logic [17:0] cand_y;
  logic [9:0]  cand_w, cand_h;
  logic [16:0] sum_x, sum_y;
  logic        vis;
  rect_t       cand;

  logic emit_ev, can_push, stall, fin_push, push;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign rx_sat = (s_axis_tdata[39:32] > 8'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                         : s_axis_tdata[32 +: RW];
  assign ry_sat = (s_axis_tdata[47:40] > 8'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                         : s_axis_tdata[40 +: RW];

  // row r of the ellipse maps to walk row |r - ry|
  assign y_idx = (r_q <= CW'(ry_q)) ? RW'(CW'(ry_q) - r_q) : RW'(r_q - CW'(ry_q));
  assign r_end = CW'({ry_q, 1'b0});

  esg_walk #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == S_WSTART),
    .rx_i     (rx_q),
    .ry_i     (ry_q),
    .done_o   (walk_done),
    .rd_addr_i(y_idx),
    .rd_data_o(half)
  );

  // span candidate; the screen clip below cuts the right edge
  assign x0s    = {2'b00, cx_q} - 18'(half);
  assign x0     = x0s[17] ? 16'd0 : x0s[15:0];
  assign span_w = {2'b00, cx_q} + 18'(half) - {2'b00, x0} + 18'd1;
  assign py     = {2'b00, cy_q} - 18'(ry_q) + 18'(r_q);

  // line candidates, start clamped at zero
  assign x_line = (cx_q > 16'(rx_q)) ? cx_q - 16'(rx_q) : 16'd0;
  assign y_line = (cy_q > 16'(ry_q)) ? cy_q - 16'(ry_q) : 16'd0;

  always_comb begin
    if (state_q == S_RUSE) begin
      cand_x = x0;
      cand_y = py;
      cand_w = span_w[9:0];
      cand_h = 10'd1;
    end else if (rx_q == '0) begin
      // vertical line, or a single pixel when both radii are zero
      cand_x = cx_q;
      cand_y = {2'b00, y_line};
      cand_w = 10'd1;
      cand_h = 10'({ry_q, 1'b1});
    end else begin
      cand_x = x_line;
      cand_y = {2'b00, cy_q};
      cand_w = 10'({rx_q, 1'b1});
      cand_h = 10'd1;
    end
  end

  assign vis   = !cand_y[17] && (cand_x < 16'(sw_q)) && (cand_y[16:0] < 17'(sh_q));
  assign sum_x = 17'(cand_x) + 17'(cand_w);
  assign sum_y = cand_y[16:0] + 17'(cand_h);

  always_comb begin
    cand.x      = cand_x[9:0];
    cand.y      = cand_y[9:0];
    cand.width  = (sum_x > 17'(sw_q)) ? sw_q - cand_x[9:0] : cand_w;
    cand.height = (sum_y > 17'(sh_q)) ? sh_q - cand_y[9:0] : cand_h;
    cand.color  = color_q;
  end

  assign emit_ev  = ((state_q == S_SPEC) || (state_q == S_RUSE)) && vis;
  assign can_push = !out_v_q || m_axis_tready;
  assign stall    = emit_ev && hold_v_q && !can_push;
  assign fin_push = (state_q == S_FIN) && hold_v_q && can_push;
  assign push     = (emit_ev && hold_v_q && can_push) || fin_push;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = ((rx_sat == '0) || (ry_sat == '0)) ? S_SPEC : S_WSTART;
      end
      S_SPEC:   if (!stall) state_d = S_FIN;
      S_WSTART: state_d = S_WWAIT;
      S_WWAIT:  if (walk_done) state_d = S_RADDR;
      S_RADDR:  state_d = S_RUSE;
      S_RUSE: begin
        if (!stall) state_d = (r_q == r_end) ? S_FIN : S_RADDR;
      end
      S_FIN:    if (!hold_v_q || can_push) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      sw_q       <= 10'd240;
      sh_q       <= 10'd240;
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      r_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        priority if (cfg_index_i == REG_SCREEN_WIDTH) begin
          sw_q <= cfg_data_i;
        end else if (cfg_index_i == REG_SCREEN_HEIGHT) begin
          sh_q <= cfg_data_i;
        end
      end
      if (accept) begin
        r_q <= '0;
      end else if ((state_q == S_RUSE) && !stall && (r_q != r_end)) begin
        r_q <= r_q + CW'(1);
      end
      if (emit_ev && !stall) begin
        hold_v_q <= 1'b1;
      end else if (fin_push) begin
        hold_v_q <= 1'b0;
      end
      if (push) begin
        out_v_q    <= 1'b1;
        out_last_q <= fin_push;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q    <= s_axis_tdata[15:0];
      cy_q    <= s_axis_tdata[31:16];
      rx_q    <= rx_sat;
      ry_q    <= ry_sat;
      color_q <= s_axis_tdata[63:48];
    end
    if (emit_ev && !stall) begin
      hold_q <= cand;
    end
    if (push) begin
      out_q <= hold_q;
    end
  end

  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tvalid = out_v_q;

endmodule

[hw/rtl/esg_walk.sv]
// ----------------------------------------------------------------------------
// esg_walk - midpoint ellipse walk with shared multiplier
// Computes the start terms on one registered multiplier, then walks the
// first quadrant one step per cycle and records the half-width of each row
// offset in a small table that the emitter reads back.
// ----------------------------------------------------------------------------
module esg_walk #(
  parameter int unsigned MAX_RADIUS = 31,
  localparam int unsigned RW = $clog2(MAX_RADIUS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [RW-1:0]          rx_i,
  input  logic [RW-1:0]          ry_i,
  output logic                   done_o,
  input  logic [RW-1:0]          rd_addr_i,
  output logic [esg_pkg::EW-1:0] rd_data_o
);
  import esg_pkg::*;

  localparam int unsigned DEPTH = MAX_RADIUS + 1;

  localparam logic [3:0] W_IDLE = 4'd0;
  localparam logic [3:0] W_M0   = 4'd1;
  localparam logic [3:0] W_M1   = 4'd2;
  localparam logic [3:0] W_M2   = 4'd3;
  localparam logic [3:0] W_M3   = 4'd4;
  localparam logic [3:0] W_R1   = 4'd5;
  localparam logic [3:0] W_Q0   = 4'd6;
  localparam logic [3:0] W_Q1   = 4'd7;
  localparam logic [3:0] W_Q2   = 4'd8;
  localparam logic [3:0] W_Q3   = 4'd9;
  localparam logic [3:0] W_Q4   = 4'd10;
  localparam logic [3:0] W_Q5   = 4'd11;
  localparam logic [3:0] W_Q6   = 4'd12;
  localparam logic [3:0] W_R2   = 4'd13;

  logic [3:0]           state_q, state_d;
  logic [XW-1:0]        x_q;
  logic signed [YW-1:0] y_q;
  logic signed [DW-1:0] d_q, dx_q, dy_q, rx2_q, ry2_q, p_q;

  logic signed [DW-1:0]   ma, mb;
  logic signed [2*DW-1:0] prod;
  logic signed [DW-1:0]   dx_n, dy_n, d_r1, d_r2, d_trunc;
  logic                   r1_go, r2_go, rec;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_q;

  assign prod = ma * mb;

  assign dx_n = dx_q + (ry2_q <<< 1);
  assign dy_n = dy_q - (rx2_q <<< 1);
  assign d_r1 = d_q[DW-1] ? (d_q + dx_n + ry2_q) : (d_q + dx_n - dy_n + ry2_q);
  assign d_r2 = (d_q > 0) ? (d_q + rx2_q - dy_n) : (d_q + dx_n - dy_n + rx2_q);
  // quarter units back to whole units, rounding toward zero
  assign d_trunc = d_q[DW-1] ? ((d_q + DW'(3)) >>> 2) : (d_q >>> 2);

  assign r1_go = (state_q == W_R1) && (dx_q < dy_q);
  assign r2_go = (state_q == W_R2) && !y_q[YW-1];
  assign rec   = r1_go || r2_go;
  assign done_o = (state_q == W_R2) && y_q[YW-1];

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      W_M0: begin
        ma = signed'(DW'(rx_i));
        mb = signed'(DW'(rx_i));
      end
      W_M1: begin
        ma = signed'(DW'(ry_i));
        mb = signed'(DW'(ry_i));
      end
      W_M2: begin
        ma = rx2_q;
        mb = signed'(DW'(ry_i));
      end
      W_Q0: begin
        ma = signed'(DW'({x_q, 1'b1}));
        mb = signed'(DW'({x_q, 1'b1}));
      end
      W_Q1: begin
        ma = ry2_q;
        mb = p_q;
      end
      W_Q2: begin
        ma = DW'(y_q) - DW'(1);
        mb = DW'(y_q) - DW'(1);
      end
      W_Q3: begin
        ma = rx2_q;
        mb = p_q;
      end
      W_Q4: begin
        ma = rx2_q;
        mb = ry2_q;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      W_IDLE:  if (start_i) state_d = W_M0;
      W_M0:    state_d = W_M1;
      W_M1:    state_d = W_M2;
      W_M2:    state_d = W_M3;
      W_M3:    state_d = W_R1;
      W_R1:    if (!r1_go) state_d = W_Q0;
      W_Q0:    state_d = W_Q1;
      W_Q1:    state_d = W_Q2;
      W_Q2:    state_d = W_Q3;
      W_Q3:    state_d = W_Q4;
      W_Q4:    state_d = W_Q5;
      W_Q5:    state_d = W_Q6;
      W_Q6:    state_d = W_R2;
      W_R2:    if (!r2_go) state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod[DW-1:0];
    unique case (state_q)
      W_M1: rx2_q <= p_q;
      W_M2: ry2_q <= p_q;
      W_M3: begin
        d_q  <= ry2_q - p_q + (rx2_q >>> 2);
        dy_q <= p_q <<< 1;
        dx_q <= '0;
        x_q  <= '0;
        y_q  <= signed'(YW'(ry_i));
      end
      W_R1: begin
        if (r1_go) begin
          x_q  <= x_q + XW'(1);
          dx_q <= dx_n;
          d_q  <= d_r1;
          if (!d_q[DW-1]) begin
            y_q  <= y_q - YW'(1);
            dy_q <= dy_n;
          end
        end
      end
      W_Q2: d_q <= p_q;
      W_Q4: d_q <= d_q + (p_q <<< 2);
      W_Q5: d_q <= d_q - (p_q <<< 2);
      W_Q6: d_q <= d_trunc;
      W_R2: begin
        if (r2_go) begin
          y_q  <= y_q - YW'(1);
          dy_q <= dy_n;
          d_q  <= d_r2;
          if (!(d_q > 0)) begin
            x_q  <= x_q + XW'(1);
            dx_q <= dx_n;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // x never shrinks along the walk, so the last write per row is its widest
  always_ff @(posedge clk_i) begin
    if (rec) begin
      mem[y_q[RW-1:0]] <= x_q[EW-1:0];
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

[hw/rtl/esg_checker.sv]
// ----------------------------------------------------------------------------
// esg_checker - port-level checks for the ellipse span generator
// Watches the stream ports and flags sequencing and payload slips.
// ----------------------------------------------------------------------------
module esg_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [esg_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready
);
  import esg_pkg::*;

  // a taken request drops input ready in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a request was taken");

  // clipped rectangles are never empty
  a_nonempty_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[29:20] != 10'd0) && (m_axis_tdata[39:30] != 10'd0))
    else $error("rectangle with zero width or height");

  // while a request still has words to send, no new request is taken
  a_mid_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken before the last word of the previous one");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

endmodule

bind ellipse_span_generator esg_checker u_esg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);
